// ===== rtl/frame_rate_resolution_regulator_core_assert.svh =====
// Assertion shorthands shared by the checker files of the frame rate regulator.
// Each macro samples on the rising edge of aclk and is off while aresetn is low.
`ifndef FRAME_RATE_RESOLUTION_REGULATOR_CORE_ASSERT_SVH
`define FRAME_RATE_RESOLUTION_REGULATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRRR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/frrr_pkg.sv =====
package frrr_pkg;

    // Default depth of the frame rate history.
    localparam int FRRR_HISTORY_LEN = 60;

    // Field widths.
    localparam int TIME_W   = 20;
    localparam int FPS_W    = 16;
    localparam int SCALE_W  = 15;
    localparam int TARGET_W = 8;
    localparam int STEP_W   = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;

    // Frame rate numerator: one second in microseconds, times 16.
    localparam int NUM_W = 24;
    localparam logic [NUM_W-1:0] FPS_NUM = 24'd16000000;
    localparam logic [FPS_W-1:0] FPS_MAX = 16'hFFFF;

    // Dead band around the target, in 1/16 fps units.
    localparam int DEADBAND = 80;

    // Register reset values.
    localparam logic [TARGET_W-1:0] TARGET_RST   = 8'd60;
    localparam logic [SCALE_W-1:0]  MIN_RST      = 15'd9830;
    localparam logic [SCALE_W-1:0]  MAX_RST      = 15'd16384;
    localparam logic [STEP_W-1:0]   STEP_DN_RST  = 12'd164;
    localparam logic [STEP_W-1:0]   STEP_UP_RST  = 12'd82;
    localparam logic [SCALE_W-1:0]  SCALE_RST    = 15'd16384;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_FPS     = 3'd0,
        REG_MIN_SCALE      = 3'd1,
        REG_MAX_SCALE      = 3'd2,
        REG_STEP_DOWN      = 3'd3,
        REG_STEP_UP        = 3'd4,
        REG_DYN_RES_ENABLE = 3'd5
    } cfg_reg_t;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== rtl/frrr_ram.sv =====
module frrr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 60,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/frrr_div.sv =====
module frrr_div #(
    parameter int WIDTH = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WIDTH-1:0]     dividend,
    input  logic [WIDTH-1:0]     divisor,
    output logic [WIDTH-1:0]     quotient,
    output frrr_pkg::div_status_t status
);

    import frrr_pkg::*;

    localparam int STEP_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [WIDTH-1:0]  rem_reg;
    logic [WIDTH-1:0]  quo_reg;
    logic [WIDTH-1:0]  dsr_reg;

    logic [WIDTH:0]    trial;
    logic              fits;
    logic [WIDTH-1:0]  rem_next;
    logic [WIDTH-1:0]  quo_next;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        trial    = {rem_reg, quo_reg[WIDTH-1]} - {1'b0, dsr_reg};
        fits     = ~trial[WIDTH];
        rem_next = fits ? trial[WIDTH-1:0] : {rem_reg[WIDTH-2:0], quo_reg[WIDTH-1]};
        quo_next = {quo_reg[WIDTH-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(WIDTH - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/frame_rate_resolution_regulator_core.sv =====
// A zero frame time goes straight to the scale adjustment and the output; a nonzero time
// takes two passes through the one bit-per-cycle divider (frame rate, then history mean).
// Input is not taken while an item works, until its result is loaded into the output register.
// Reset: synchronous, active-low aresetn restores register defaults, clears history state
// and sets the scale to 1.0; history memory contents are not cleared.
module frame_rate_resolution_regulator_core #(
    parameter int HISTORY_LEN = frrr_pkg::FRRR_HISTORY_LEN
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [frrr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [frrr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [frrr_pkg::S_TDATA_W-1:0]   s_tdata,  // [19:0] frame_time_us, [23:20] zero
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] current_fps, [31:16] average_fps, [46:32] resolution_scale, [47] target_met
    output logic [frrr_pkg::M_TDATA_W-1:0]   m_tdata
);

    import frrr_pkg::*;

    // History count must hold HISTORY_LEN itself; the sum holds HISTORY_LEN full-scale rates.
    localparam int CNT_W  = $clog2(HISTORY_LEN + 1);
    localparam int SLOT_W = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam int SUM_W  = FPS_W + CNT_W;
    localparam int DIV_W  = (SUM_W > NUM_W) ? SUM_W : NUM_W;
    localparam int DIFF_W = FPS_W + 2;
    localparam int CAND_W = SCALE_W + 2;
    localparam int MET_W  = FPS_W + 4;

    localparam logic signed [DIFF_W-1:0] DB_HI = DIFF_W'(DEADBAND);
    localparam logic signed [DIFF_W-1:0] DB_LO = -DB_HI;

    // The sequencer walks an item with a nonzero frame time through the shared divider twice.
    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_FPS_DIV  = 6'b000010,
        ST_UPDATE   = 6'b000100,
        ST_MEAN_DIV = 6'b001000,
        ST_ADJUST   = 6'b010000,
        ST_OUTPUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [TARGET_W-1:0] target_reg;
    logic [SCALE_W-1:0]  min_scale_reg;
    logic [SCALE_W-1:0]  max_scale_reg;
    logic [STEP_W-1:0]   step_down_reg;
    logic [STEP_W-1:0]   step_up_reg;
    logic                dyn_en_reg;

    // Regulator state.
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [FPS_W-1:0]    latest_reg;
    logic [FPS_W-1:0]    mean_reg;
    logic [SCALE_W-1:0]  scale_reg, scale_next;
    logic                met_reg, met_next;

    // Output register.
    logic                m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // Shared divider connections.
    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [DIV_W-1:0]    div_divisor;
    logic [DIV_W-1:0]    div_quotient;
    div_status_t         div_status;

    // History memory.
    logic [FPS_W-1:0]    hist_rdata;
    logic                hist_we;

    logic [TIME_W-1:0]   frame_time;
    logic                in_fire;
    logic                hist_full;
    logic [FPS_W-1:0]    evicted;
    logic [FPS_W-1:0]    fps_sat;
    logic                out_load;

    logic signed [DIFF_W-1:0] diff;
    logic signed [CAND_W-1:0] cand_dn;
    logic signed [CAND_W-1:0] cand_up;
    logic signed [CAND_W-1:0] cand;
    logic signed [CAND_W-1:0] lo_bound;
    logic signed [CAND_W-1:0] hi_bound;
    logic                     too_slow;
    logic                     too_fast;
    logic [MET_W-1:0]         mean_x10;
    logic [MET_W-1:0]         target_x144;

    assign frame_time = s_tdata[TIME_W-1:0];
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign hist_full  = (count_reg == CNT_W'(HISTORY_LEN));
    assign out_load   = (state_reg == ST_OUTPUT) && (!m_valid_reg || m_tready);

    // Configuration writes; indexes past the register list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= TARGET_RST;
            min_scale_reg <= MIN_RST;
            max_scale_reg <= MAX_RST;
            step_down_reg <= STEP_DN_RST;
            step_up_reg   <= STEP_UP_RST;
            dyn_en_reg    <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TARGET_FPS:     target_reg    <= cfg_wdata[TARGET_W-1:0];
                REG_MIN_SCALE:      min_scale_reg <= cfg_wdata[SCALE_W-1:0];
                REG_MAX_SCALE:      max_scale_reg <= cfg_wdata[SCALE_W-1:0];
                REG_STEP_DOWN:      step_down_reg <= cfg_wdata[STEP_W-1:0];
                REG_STEP_UP:        step_up_reg   <= cfg_wdata[STEP_W-1:0];
                REG_DYN_RES_ENABLE: dyn_en_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // The divider first forms 16e6 / time, then the history sum over the entry count.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = DIV_W'(FPS_NUM);
        div_divisor  = DIV_W'(frame_time);
        if (state_reg == ST_UPDATE) begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(sum_next);
            div_divisor  = DIV_W'(count_next);
        end else if (in_fire && (frame_time != '0)) begin
            div_start = 1'b1;
        end
    end

    frrr_div #(
        .WIDTH (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // Rates above the 16-bit range saturate.
    assign fps_sat = (div_quotient[DIV_W-1:FPS_W] != '0) ? FPS_MAX : div_quotient[FPS_W-1:0];

    // The history is read at the write slot all the time; the entry to evict is ready
    // long before the update step needs it.
    assign hist_we = (state_reg == ST_UPDATE);

    frrr_ram #(
        .WIDTH (FPS_W),
        .DEPTH (HISTORY_LEN)
    ) u_hist (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (slot_reg),
        .wdata (latest_reg),
        .raddr (slot_reg),
        .rdata (hist_rdata)
    );

    // Running sum, entry count and write slot for the new rate. An entry is only
    // read back once the history is full, so it has always been written.
    always_comb begin
        evicted    = hist_full ? hist_rdata : '0;
        sum_next   = sum_reg - SUM_W'(evicted) + SUM_W'(latest_reg);
        count_next = hist_full ? count_reg : count_reg + 1'b1;
        slot_next  = (slot_reg == SLOT_W'(HISTORY_LEN - 1)) ? '0 : slot_reg + 1'b1;
    end

    // Scale adjustment with a dead band of five fps around the target, then the clamp.
    // The clamp tests the lower bound first, so crossed bounds give one of the bounds.
    always_comb begin
        diff     = $signed({2'b00, latest_reg}) - $signed(DIFF_W'({target_reg, 4'b0000}));
        too_slow = diff < DB_LO;
        too_fast = diff > DB_HI;
        cand_dn  = $signed({2'b00, scale_reg}) - $signed(CAND_W'(step_down_reg));
        cand_up  = $signed({2'b00, scale_reg}) + $signed(CAND_W'(step_up_reg));
        cand     = too_slow ? cand_dn : cand_up;
        lo_bound = $signed({2'b00, min_scale_reg});
        hi_bound = $signed({2'b00, max_scale_reg});
        scale_next = scale_reg;
        if (dyn_en_reg && (too_slow || too_fast)) begin
            if (cand < lo_bound) begin
                scale_next = min_scale_reg;
            end else if (cand < hi_bound) begin
                scale_next = cand[SCALE_W-1:0];
            end else begin
                scale_next = max_scale_reg;
            end
        end
        // Ninety percent of target, in 1/16 fps: 10 * mean >= 144 * target.
        mean_x10    = MET_W'(mean_reg) * MET_W'(10);
        target_x144 = MET_W'(target_reg) * MET_W'(144);
        met_next    = mean_x10 >= target_x144;
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (frame_time != '0) ? ST_FPS_DIV : ST_ADJUST;
                end
            end
            ST_FPS_DIV: begin
                if (div_status.done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_MEAN_DIV;
            end
            ST_MEAN_DIV: begin
                if (div_status.done) begin
                    state_next = ST_ADJUST;
                end
            end
            ST_ADJUST: begin
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            count_reg   <= '0;
            slot_reg    <= '0;
            latest_reg  <= '0;
            mean_reg    <= '0;
            scale_reg   <= SCALE_RST;
            met_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_FPS_DIV) && div_status.done) begin
                latest_reg <= fps_sat;
            end
            if (state_reg == ST_UPDATE) begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                slot_reg  <= slot_next;
            end
            if ((state_reg == ST_MEAN_DIV) && div_status.done) begin
                mean_reg <= div_quotient[FPS_W-1:0];
            end
            if (state_reg == ST_ADJUST) begin
                scale_reg <= scale_next;
                met_reg   <= met_next;
            end
            // The output register holds a finished result while the next item is taken.
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {met_reg, scale_reg, mean_reg, latest_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/frrr_chk.sv =====
`include "frame_rate_resolution_regulator_core_assert.svh"

module frrr_chk (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [frrr_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result keeps its value.
    `FRRR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // The block works on one item at a time, so it stops taking input after a transaction.
    `FRRR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken while an item is in work")

    // No result can appear in the cycle right after an input transaction.
    `FRRR_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid), "result appeared too early")

endmodule

bind frame_rate_resolution_regulator_core frrr_chk u_frrr_chk (.*);

// ===== bench/frrr_result_checker.sv =====
`timescale 1ns / 100ps

// Watches the register port and both streams of the frame rate regulator.
// It keeps its own copy of the regulator state, predicts one readout per
// accepted frame time, and compares every accepted readout with the oldest
// prediction.
module frrr_result_checker
    import frrr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    output int                    fail_count,
    output int                    pending_count,
    output int                    checked_count
);

    localparam int HIST = FRRR_HISTORY_LEN;

    // Packed in the same order as m_tdata, lowest field last.
    typedef struct packed {
        logic               met;
        logic [SCALE_W-1:0] scale;
        logic [FPS_W-1:0]   mean;
        logic [FPS_W-1:0]   fps;
    } readout_t;

    // Register copy.
    logic [TARGET_W-1:0] goal_fps;
    logic [SCALE_W-1:0]  scale_floor;
    logic [SCALE_W-1:0]  scale_ceil;
    logic [STEP_W-1:0]   shrink_step;
    logic [STEP_W-1:0]   grow_step;
    logic                adjust_on;

    // Regulator state copy.
    logic [FPS_W-1:0]   rate_log [HIST];
    logic [21:0]        rate_sum;
    logic [5:0]         rate_count;
    logic [5:0]         next_slot;
    logic [FPS_W-1:0]   last_rate;
    logic [FPS_W-1:0]   avg_rate;
    logic [SCALE_W-1:0] scale_reg;

    readout_t predicted_readouts[$];
    readout_t want;
    readout_t got;
    int       fails;
    int       checked;

    function automatic logic [SCALE_W-1:0] bound_scale(input int x);
        if (x < int'(scale_floor))
            return scale_floor;
        if (x < int'(scale_ceil))
            return x[SCALE_W-1:0];
        return scale_ceil;
    endfunction

    // Advances the state copy by one frame time and returns the readout.
    function automatic readout_t regulate_frame(input logic [TIME_W-1:0] t);
        logic [31:0] rate;
        int          diff;
        readout_t    r;
        if (t != 0) begin
            rate = 32'(FPS_NUM) / 32'(t);
            if (rate > 32'(FPS_MAX))
                rate = 32'(FPS_MAX);
            last_rate = rate[FPS_W-1:0];
            if (next_slot >= HIST)
                next_slot = 0;
            if (rate_count >= HIST)
                rate_sum = rate_sum - rate_log[next_slot];
            else
                rate_count = rate_count + 1;
            rate_log[next_slot] = last_rate;
            rate_sum = rate_sum + last_rate;
            next_slot = next_slot + 1;
            if (next_slot >= HIST)
                next_slot = 0;
            avg_rate = (rate_count != 0) ? FPS_W'(rate_sum / rate_count) : '0;
        end
        if (adjust_on) begin
            diff = int'(last_rate) - int'(goal_fps) * 16;
            if (diff < -DEADBAND)
                scale_reg = bound_scale(int'(scale_reg) - int'(shrink_step));
            else if (diff > DEADBAND)
                scale_reg = bound_scale(int'(scale_reg) + int'(grow_step));
        end
        r.fps   = last_rate;
        r.mean  = avg_rate;
        r.scale = scale_reg;
        r.met   = (32'(avg_rate) * 10 >= 32'(goal_fps) * 144);
        return r;
    endfunction

    initial begin
        fails = 0;
        checked = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            goal_fps    = TARGET_RST;
            scale_floor = MIN_RST;
            scale_ceil  = MAX_RST;
            shrink_step = STEP_DN_RST;
            grow_step   = STEP_UP_RST;
            adjust_on   = 1'b1;
            rate_sum    = '0;
            rate_count  = '0;
            next_slot   = '0;
            last_rate   = '0;
            avg_rate    = '0;
            scale_reg   = SCALE_RST;
            predicted_readouts.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TARGET_FPS:     goal_fps    = cfg_wdata[TARGET_W-1:0];
                    REG_MIN_SCALE:      scale_floor = cfg_wdata[SCALE_W-1:0];
                    REG_MAX_SCALE:      scale_ceil  = cfg_wdata[SCALE_W-1:0];
                    REG_STEP_DOWN:      shrink_step = cfg_wdata[STEP_W-1:0];
                    REG_STEP_UP:        grow_step   = cfg_wdata[STEP_W-1:0];
                    REG_DYN_RES_ENABLE: adjust_on   = cfg_wdata[0];
                    default: ;
                endcase
            end
            // The older readout leaves before a new frame time is predicted.
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                checked++;
                if (predicted_readouts.size() == 0) begin
                    fails++;
                    $display("%0t: readout %h arrived with none predicted", $time, got);
                end else begin
                    want = predicted_readouts.pop_front();
                    if (got.fps !== want.fps) begin
                        fails++;
                        $display("%0t: current_fps expected %0d, actual %0d",
                                 $time, want.fps, got.fps);
                    end
                    if (got.mean !== want.mean) begin
                        fails++;
                        $display("%0t: average_fps expected %0d, actual %0d",
                                 $time, want.mean, got.mean);
                    end
                    if (got.scale !== want.scale) begin
                        fails++;
                        $display("%0t: resolution_scale expected %0d, actual %0d",
                                 $time, want.scale, got.scale);
                    end
                    if (got.met !== want.met) begin
                        fails++;
                        $display("%0t: target_met expected %b, actual %b",
                                 $time, want.met, got.met);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predicted_readouts.push_back(regulate_frame(s_tdata[TIME_W-1:0]));
        end
        fail_count    <= fails;
        pending_count <= predicted_readouts.size();
        checked_count <= checked;
    end

endmodule

// ===== bench/frame_rate_resolution_regulator_core_test.sv =====
`timescale 1ns / 100ps

// Top of the regulator bench. This module only makes stimulus and gives the
// verdict; prediction and comparison live in the checker beside the block.
module frame_rate_resolution_regulator_core_test;
    import frrr_pkg::*;

    // Even a nonzero frame time, with its two divider passes, is done far sooner than
    // WATCHDOG_LIMIT quiet cycles, so reaching the limit can only mean the block has hung.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PHASES         = 12;
    localparam int FRAMES_PER_PHASE = 120;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_HI = 3'd7;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    int fail_count;
    int pending_count;
    int checked_count;

    // Percent chance of a gap cycle on the input side and of a stall cycle
    // on the result side. The stall rate changes by nonblocking assignment
    // so that the receiver process never races with a mode change.
    int send_gap_pct = 0;
    int recv_gap_pct = 0;

    int frames_sent   = 0;
    int zero_frames   = 0;
    int settings_used = 0;
    int quiet_cycles  = 0;

    frame_rate_resolution_regulator_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    frrr_result_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The receiver decides each cycle whether it can take a result.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // The watchdog ends the run when no transaction of any kind has happened
    // for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout at %0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Presents one frame time, after a random number of gap cycles, and
    // returns at the edge where the transaction completes. Valid stays high
    // into the next call when no gap follows, so it is never lowered and
    // raised in the same step.
    task automatic send_frame(input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-TIME_W){1'b0}}, t};
        do @(posedge aclk); while (!s_tready);
        frames_sent++;
        if (t == 0)
            zero_frames++;
    endtask

    // Waits until every predicted readout has come back, then lets a few
    // more cycles pass so that the block is surely idle before any register
    // write. The pending count is registered, so it never reads zero at the
    // edge where a frame time was just taken.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Writes all six registers plus one spare index. Bits above the width of each register
    // narrower than the data port carry random junk, which the block must drop.
    task automatic apply_settings(input logic [TARGET_W-1:0] target,
                                  input logic [SCALE_W-1:0] lo,
                                  input logic [SCALE_W-1:0] hi,
                                  input logic [STEP_W-1:0] dn,
                                  input logic [STEP_W-1:0] up,
                                  input logic en);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom_range(16'h7FFF);
        write_reg(REG_TARGET_FPS, {junk[14:8], target});
        write_reg(REG_MIN_SCALE, lo);
        write_reg(REG_MAX_SCALE, hi);
        junk = $urandom_range(16'h7FFF);
        write_reg(REG_STEP_DOWN, {junk[14:12], dn});
        junk = $urandom_range(16'h7FFF);
        write_reg(REG_STEP_UP, {junk[14:12], up});
        junk = $urandom_range(16'h7FFF);
        write_reg(REG_DYN_RES_ENABLE, {junk[14:1], en});
        junk = $urandom_range(16'h7FFF);
        write_reg(junk[0] ? SPARE_INDEX_HI : SPARE_INDEX_LO, junk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    // Most frame times land within a few fps of the target, so the scale
    // keeps crossing the dead band in both directions. The rest are zero
    // times, short times around the saturation edge and whole-field values.
    function automatic logic [TIME_W-1:0] pick_frame_time(input int target);
        int roll;
        int rate;
        int t;
        roll = $urandom_range(99);
        if (roll < 55) begin
            rate = target * 16 + int'($urandom_range(400)) - 200;
            if (rate < 1)
                rate = 1;
            t = 16000000 / rate;
            if (t > 1048575)
                t = 1048575;
            if (t < 1)
                t = 1;
        end else if (roll < 65) begin
            t = 0;
        end else if (roll < 75) begin
            t = $urandom_range(1, 400);
        end else begin
            t = $urandom_range(20'hFFFFF);
        end
        return t[TIME_W-1:0];
    endfunction

    initial begin
        logic [TIME_W-1:0] opening_times [11];
        int                goal;
        int                lo;
        int                hi;
        int                dn;
        int                up;
        int                en;

        // Zero right after reset, saturation, the saturation edge, the slowest
        // frame, and times just inside and outside both edges of the dead band
        // around the reset target of 60 fps.
        opening_times = '{20'd0, 20'd1, 20'd244, 20'd245, 20'd1048575, 20'd18181,
                          20'd18182, 20'd15384, 20'd15369, 20'd16666, 20'd0};

        // The sender idles rarely and the receiver often in the first third.
        send_gap_pct = 8;
        recv_gap_pct <= 48;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset register values first, with the history still empty.
        foreach (opening_times[i])
            send_frame(opening_times[i]);
        settle();

        // A target of zero: the target flag is always set.
        apply_settings(8'd0, 15'd0, 15'd32767, 12'd4095, 12'd4095, 1'b1);
        send_frame(20'd1048575);
        send_frame(20'd0);
        send_frame(20'd1);
        send_frame(20'd245);
        settle();

        // Lower bound above the upper bound: a step lands on one bound or the
        // other, never on the candidate itself.
        apply_settings(8'd255, 15'd20000, 15'd10000, 12'd4095, 12'd4095, 1'b1);
        send_frame(20'd1);
        send_frame(20'd1048575);
        send_frame(20'd1048575);
        settle();

        // Adjustment off: the scale holds whatever the frame rate.
        apply_settings(8'd60, 15'd0, 15'd32767, 12'd4095, 12'd4095, 1'b0);
        send_frame(20'd1);
        send_frame(20'd1048575);
        settle();

        // New bounds with the held scale on their lower edge. Inside the dead band it
        // must stay as it is; the next real step, downward, is held at that lower bound.
        apply_settings(8'd60, 15'd20000, 15'd24000, 12'd100, 12'd100, 1'b1);
        send_frame(20'd16666);
        send_frame(20'd18182);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            // Then the other way round, and at last traffic with no idling.
            if (phase == PHASES / 3) begin
                send_gap_pct = 48;
                recv_gap_pct <= 8;
            end
            if (phase == 2 * PHASES / 3) begin
                send_gap_pct = 0;
                recv_gap_pct <= 0;
            end

            if (phase % 4 == 0)
                goal = (phase % 8 == 0) ? 255 : 1;
            else
                goal = $urandom_range(1, 255);

            if (phase % 3 == 0) begin
                lo = 0;
                hi = 32767;
            end else if (phase % 5 == 1) begin
                lo = $urandom_range(16384, 32767);
                hi = $urandom_range(0, 16383);
            end else begin
                lo = $urandom_range(0, 16384);
                hi = $urandom_range(lo, 32767);
            end

            if (phase % 4 == 2) begin
                dn = 4095;
                up = 4095;
            end else if (phase % 4 == 3) begin
                dn = 0;
                up = $urandom_range(0, 600);
            end else begin
                dn = $urandom_range(0, 600);
                up = $urandom_range(0, 600);
            end

            en = (phase % 6 == 5) ? 0 : 1;

            apply_settings(goal[TARGET_W-1:0], lo[SCALE_W-1:0], hi[SCALE_W-1:0],
                           dn[STEP_W-1:0], up[STEP_W-1:0], en[0]);
            repeat (FRAMES_PER_PHASE)
                send_frame(pick_frame_time(goal));
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d frame times (%0d of them zero) under %0d register settings.",
                 frames_sent, zero_frames, settings_used);
        $display("Compared %0d readouts with sender-heavy, receiver-heavy and gapless idling.",
                 checked_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
